FILE: rtl/mfda_pkg.sv
package mfda_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 7;

    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 12;
    localparam int ANGLE_W = 16;
    localparam int CNT_W   = 2;
    localparam int STEP_W  = 5;

    localparam int VEC_SHIFT = 8;
    localparam int VEC_W     = 23;
    localparam int ACC_FRAC  = 16;
    localparam int ACC_W     = 26;

    localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ACC_P90   = ACC_W'(90 * (1 << ACC_FRAC));
    localparam logic signed [ACC_W-1:0] ACC_N90   = -ACC_W'(90 * (1 << ACC_FRAC));
    localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(1 << (RND_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] ANG_P90   = ACC_W'(90 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [ACC_W-1:0] ANG_N90   = -ACC_W'(90 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [ACC_W-1:0] ANG_LIM   = ACC_W'(180 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [ACC_W-1:0] ANG_NLIM  = -ACC_W'(180 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [ACC_W-1:0] ANG_S_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ANG_S_MIN = -ACC_W'(32768);

    typedef logic signed [FIELD_W-1:0] t_field;

    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ACC_W-1:0] acc;
        t_field                  x;
        t_field                  y;
        t_field                  z;
        logic                    stuck;
    } t_cordic;

    // atan(2^-i) in degrees, Q.16
    function automatic logic signed [ACC_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        unique case (idx)
            5'd0:    v = ACC_W'(2949120);
            5'd1:    v = ACC_W'(1740967);
            5'd2:    v = ACC_W'(919879);
            5'd3:    v = ACC_W'(466945);
            5'd4:    v = ACC_W'(234379);
            5'd5:    v = ACC_W'(117304);
            5'd6:    v = ACC_W'(58666);
            5'd7:    v = ACC_W'(29335);
            5'd8:    v = ACC_W'(14668);
            5'd9:    v = ACC_W'(7334);
            5'd10:   v = ACC_W'(3667);
            5'd11:   v = ACC_W'(1833);
            5'd12:   v = ACC_W'(917);
            5'd13:   v = ACC_W'(458);
            5'd14:   v = ACC_W'(229);
            5'd15:   v = ACC_W'(115);
            5'd16:   v = ACC_W'(57);
            5'd17:   v = ACC_W'(29);
            5'd18:   v = ACC_W'(14);
            5'd19:   v = ACC_W'(7);
            5'd20:   v = ACC_W'(4);
            5'd21:   v = ACC_W'(2);
            5'd22:   v = ACC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/mfda_frame_if.sv
interface mfda_frame_if;
    logic                            valid;
    logic                            ready;
    logic [mfda_pkg::BYTE_W-1:0]     frame_byte0;
    logic [mfda_pkg::BYTE_W-1:0]     frame_byte1;
    logic [mfda_pkg::BYTE_W-1:0]     frame_byte2;
    logic [mfda_pkg::BYTE_W-1:0]     frame_byte3;
    logic [mfda_pkg::BYTE_W-1:0]     frame_byte4;
    logic [mfda_pkg::BYTE_W-1:0]     frame_byte5;

    modport source (
        output valid, frame_byte0, frame_byte1, frame_byte2,
               frame_byte3, frame_byte4, frame_byte5,
        input  ready
    );
    modport sink (
        input  valid, frame_byte0, frame_byte1, frame_byte2,
               frame_byte3, frame_byte4, frame_byte5,
        output ready
    );
endinterface

FILE: rtl/mfda_result_if.sv
interface mfda_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mfda_pkg::FIELD_W-1:0]  field_x;
    logic signed [mfda_pkg::FIELD_W-1:0]  field_y;
    logic signed [mfda_pkg::FIELD_W-1:0]  field_z;
    logic signed [mfda_pkg::ANGLE_W-1:0]  angle_deg;
    logic                                 stuck;

    modport source (
        output valid, field_x, field_y, field_z, angle_deg, stuck,
        input  ready
    );
    modport sink (
        input  valid, field_x, field_y, field_z, angle_deg, stuck,
        output ready
    );
endinterface

FILE: rtl/magnetic_frame_decode_angle_core.sv
// channel   dir  payload                                     handshake
// i_frame   in   frame_byte0..frame_byte5, 8 bits each        valid/ready
// o_result  out  field_x/y/z (s12), angle_deg (s16), stuck    valid/ready
//
// One frame per cycle while the output is not stalled; stages: unpack stage,
// one cell per CORDIC iteration, round/clamp output register.
// Each stage holds its item until the next one frees; a stalled output
// holds back only the unbroken run of full stages behind it, so bubbles in the chain still take items.
// Reset clears the stage valids and the last frame counter.
module magnetic_frame_decode_angle_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mfda_frame_if.sink    i_frame,
    mfda_result_if.source o_result
);

    localparam int N = mfda_pkg::CORDIC_STEPS;

    logic              w_vld [N+1];
    logic              w_rdy [N+1];
    mfda_pkg::t_cordic w_dat [N+1];

    mfda_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (i_frame),
        .o_vld   (w_vld[0]),
        .o_dat   (w_dat[0]),
        .i_rdy   (w_rdy[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cell
        mfda_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (mfda_pkg::STEP_W'(k)),
            .i_vld   (w_vld[k]),
            .i_dat   (w_dat[k]),
            .o_rdy   (w_rdy[k]),
            .o_vld   (w_vld[k+1]),
            .o_dat   (w_dat[k+1]),
            .i_rdy   (w_rdy[k+1])
        );
    end

    mfda_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_vld[N]),
        .i_dat    (w_dat[N]),
        .o_rdy    (w_rdy[N]),
        .o_result (o_result)
    );

endmodule

FILE: rtl/mfda_unpack.sv
module mfda_unpack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mfda_frame_if.sink        i_frame,
    output logic              o_vld,
    output mfda_pkg::t_cordic o_dat,
    input  logic              i_rdy
);

    logic                           r_vld;
    mfda_pkg::t_cordic              r_dat;
    logic [mfda_pkg::CNT_W-1:0]     r_last;

    logic                           w_acc;
    mfda_pkg::t_field               w_x;
    mfda_pkg::t_field               w_y;
    logic [mfda_pkg::CNT_W-1:0]     w_cnt;
    logic                           w_stuck;
    logic signed [mfda_pkg::VEC_W-1:0] w_vx0;
    logic signed [mfda_pkg::VEC_W-1:0] w_vy0;
    mfda_pkg::t_cordic              n_dat;

    assign i_frame.ready = !r_vld || i_rdy;
    assign w_acc         = i_frame.valid && i_frame.ready;

    assign w_x     = {i_frame.frame_byte0, i_frame.frame_byte4[7:4]};
    assign w_y     = {i_frame.frame_byte1, i_frame.frame_byte4[3:0]};
    assign w_cnt   = i_frame.frame_byte3[3:2];
    assign w_stuck = (w_cnt == r_last);

    assign w_vx0 = {{(mfda_pkg::VEC_W - mfda_pkg::FIELD_W - mfda_pkg::VEC_SHIFT){w_x[11]}},
                    w_x, {mfda_pkg::VEC_SHIFT{1'b0}}};
    assign w_vy0 = {{(mfda_pkg::VEC_W - mfda_pkg::FIELD_W - mfda_pkg::VEC_SHIFT){w_y[11]}},
                    w_y, {mfda_pkg::VEC_SHIFT{1'b0}}};

    always_comb begin
        n_dat.x     = w_x;
        n_dat.y     = w_y;
        n_dat.z     = {i_frame.frame_byte2, i_frame.frame_byte5[3:0]};
        n_dat.stuck = w_stuck;
        n_dat.vx    = w_vx0;
        n_dat.vy    = w_vy0;
        n_dat.acc   = '0;
        // left half plane: rotate by a quarter turn first
        if (w_x[11]) begin
            if (!w_y[11]) begin
                n_dat.vx  = w_vy0;
                n_dat.vy  = -w_vx0;
                n_dat.acc = mfda_pkg::ACC_P90;
            end else begin
                n_dat.vx  = -w_vy0;
                n_dat.vy  = w_vx0;
                n_dat.acc = mfda_pkg::ACC_N90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_last <= '0;
        end else begin
            if (i_frame.ready) begin
                r_vld <= i_frame.valid;
            end
            if (w_acc) begin
                r_last <= w_stuck ? '0 : w_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_dat <= n_dat;
        end
    end

    assign o_vld = r_vld;
    assign o_dat = r_dat;

endmodule

FILE: rtl/mfda_cordic_cell.sv
module mfda_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mfda_pkg::STEP_W-1:0]   i_step,
    input  logic                          i_vld,
    input  mfda_pkg::t_cordic             i_dat,
    output logic                          o_rdy,
    output logic                          o_vld,
    output mfda_pkg::t_cordic             o_dat,
    input  logic                          i_rdy
);

    logic                              r_vld;
    mfda_pkg::t_cordic                 r_dat;
    mfda_pkg::t_cordic                 n_dat;
    logic signed [mfda_pkg::VEC_W-1:0] w_dx;
    logic signed [mfda_pkg::VEC_W-1:0] w_dy;
    logic signed [mfda_pkg::ACC_W-1:0] w_ang;

    assign o_rdy = !r_vld || i_rdy;
    assign w_dx  = i_dat.vy >>> i_step;
    assign w_dy  = i_dat.vx >>> i_step;
    assign w_ang = mfda_pkg::atan_q16(i_step);

    always_comb begin
        n_dat = i_dat;
        if (!i_dat.vy[mfda_pkg::VEC_W-1]) begin
            n_dat.vx  = i_dat.vx + w_dx;
            n_dat.vy  = i_dat.vy - w_dy;
            n_dat.acc = i_dat.acc + w_ang;
        end else begin
            n_dat.vx  = i_dat.vx - w_dx;
            n_dat.vy  = i_dat.vy + w_dy;
            n_dat.acc = i_dat.acc - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_dat <= n_dat;
        end
    end

    assign o_vld = r_vld;
    assign o_dat = r_dat;

endmodule

FILE: rtl/mfda_round.sv
module mfda_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  mfda_pkg::t_cordic i_dat,
    output logic              o_rdy,
    mfda_result_if.source     o_result
);

    logic                                r_vld;
    mfda_pkg::t_field                    r_x;
    mfda_pkg::t_field                    r_y;
    mfda_pkg::t_field                    r_z;
    logic signed [mfda_pkg::ANGLE_W-1:0] r_ang;
    logic                                r_stuck;

    logic signed [mfda_pkg::ACC_W-1:0]   w_rnd;
    logic signed [mfda_pkg::ACC_W-1:0]   w_res;
    logic signed [mfda_pkg::ACC_W-1:0]   n_ang;

    assign o_rdy = !r_vld || o_result.ready;
    assign w_rnd = i_dat.acc + mfda_pkg::RND_HALF;
    assign w_res = w_rnd >>> mfda_pkg::RND_SHIFT;

    always_comb begin
        n_ang = w_res;
        if (n_ang > mfda_pkg::ANG_LIM) begin
            n_ang = mfda_pkg::ANG_LIM;
        end
        if (n_ang < mfda_pkg::ANG_NLIM) begin
            n_ang = mfda_pkg::ANG_NLIM;
        end
        if (n_ang > mfda_pkg::ANG_S_MAX) begin
            n_ang = mfda_pkg::ANG_S_MAX;
        end
        if (n_ang < mfda_pkg::ANG_S_MIN) begin
            n_ang = mfda_pkg::ANG_S_MIN;
        end
        // X on the axis: straight up or down
        if (i_dat.x == '0) begin
            n_ang = i_dat.y[mfda_pkg::FIELD_W-1] ? mfda_pkg::ANG_N90 : mfda_pkg::ANG_P90;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_x     <= i_dat.x;
            r_y     <= i_dat.y;
            r_z     <= i_dat.z;
            r_ang   <= n_ang[mfda_pkg::ANGLE_W-1:0];
            r_stuck <= i_dat.stuck;
        end
    end

    assign o_result.valid     = r_vld;
    assign o_result.field_x   = r_x;
    assign o_result.field_y   = r_y;
    assign o_result.field_z   = r_z;
    assign o_result.angle_deg = r_ang;
    assign o_result.stuck     = r_stuck;

endmodule

FILE: tb/magnetic_frame_decode_angle_core_tb.sv
`timescale 1ns / 1ps

module magnetic_frame_decode_angle_core_tb;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RAND_PER_PHASE = 517;
    localparam int N_DIRECTED     = 21;
    localparam int DRAIN_CYCLES   = mfda_pkg::CORDIC_STEPS + 12;
    localparam int ATAN_LEN       = 24;

    // atan(2^-i) in degrees, Q.16
    localparam int ATAN_DEG_Q16 [ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [mfda_pkg::BYTE_W-1:0] frame_byte0;
        logic [mfda_pkg::BYTE_W-1:0] frame_byte1;
        logic [mfda_pkg::BYTE_W-1:0] frame_byte2;
        logic [mfda_pkg::BYTE_W-1:0] frame_byte3;
        logic [mfda_pkg::BYTE_W-1:0] frame_byte4;
        logic [mfda_pkg::BYTE_W-1:0] frame_byte5;
    } t_frame;

    typedef struct packed {
        mfda_pkg::t_field                    field_x;
        mfda_pkg::t_field                    field_y;
        mfda_pkg::t_field                    field_z;
        logic signed [mfda_pkg::ANGLE_W-1:0] angle_deg;
        logic                                stuck;
    } t_reading;

    typedef struct packed {
        t_frame   frame;
        logic     fixed_want;
        t_reading want;
    } t_row;

    // fixed_want rows carry a hand-written reading, the rest use the predictor
    t_row directed [N_DIRECTED] = '{
        '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{12'h000, 12'h000, 12'h000, 16'sd11520, 1'b1}},
        '{'{8'h00, 8'hFF, 8'h7F, 8'h04, 8'h0F, 8'h0F}, 1'b1,
          '{12'h000, 12'hFFF, 12'h7FF, -16'sd11520, 1'b0}},
        '{'{8'h00, 8'h7F, 8'h80, 8'hF7, 8'h0F, 8'hF0}, 1'b1,
          '{12'h000, 12'h7FF, 12'h800, 16'sd11520, 1'b1}},
        '{'{8'h00, 8'h80, 8'hFF, 8'h08, 8'h00, 8'hFF}, 1'b1,
          '{12'h000, 12'h800, 12'hFFF, -16'sd11520, 1'b0}},
        '{'{8'h00, 8'h00, 8'h00, 8'h0C, 8'h00, 8'h00}, 1'b1,
          '{12'h000, 12'h000, 12'h000, 16'sd11520, 1'b0}},
        '{'{8'h80, 8'h00, 8'h00, 8'h0C, 8'h00, 8'h00}, 1'b0, '0},
        '{'{8'h7F, 8'h00, 8'h00, 8'h00, 8'hF0, 8'h00}, 1'b0, '0},
        '{'{8'hFF, 8'h00, 8'h00, 8'h04, 8'hF0, 8'h00}, 1'b0, '0},
        '{'{8'hFF, 8'hFF, 8'h00, 8'h08, 8'hFF, 8'h00}, 1'b0, '0},
        '{'{8'hFF, 8'h00, 8'h00, 8'h0C, 8'hF1, 8'h00}, 1'b0, '0},
        '{'{8'h00, 8'h00, 8'h00, 8'h0C, 8'h10, 8'h00}, 1'b0, '0},
        '{'{8'h00, 8'hFF, 8'h00, 8'h00, 8'h1F, 8'h00}, 1'b0, '0},
        '{'{8'h80, 8'h80, 8'h00, 8'h04, 8'h00, 8'h00}, 1'b0, '0},
        '{'{8'h80, 8'h7F, 8'h00, 8'h08, 8'h0F, 8'h00}, 1'b0, '0},
        '{'{8'h7F, 8'h7F, 8'h00, 8'h0C, 8'hFF, 8'h00}, 1'b0, '0},
        '{'{8'h7F, 8'h80, 8'h00, 8'h00, 8'hF0, 8'h00}, 1'b0, '0},
        '{'{8'h80, 8'hFF, 8'h00, 8'h04, 8'h0F, 8'h00}, 1'b0, '0},
        '{'{8'h00, 8'h7F, 8'h00, 8'h08, 8'h1F, 8'h00}, 1'b0, '0},
        '{'{8'h00, 8'h80, 8'h00, 8'h0C, 8'h10, 8'h00}, 1'b0, '0},
        '{'{8'hFF, 8'h80, 8'h00, 8'h00, 8'hF0, 8'h00}, 1'b0, '0},
        '{'{8'h80, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF}, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    mfda_frame_if  frame_bus ();
    mfda_result_if result_bus ();

    magnetic_frame_decode_angle_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_bus),
        .o_result (result_bus)
    );

    t_reading                   readings_due [$];
    logic [mfda_pkg::CNT_W-1:0] prev_count;
    logic [mfda_pkg::CNT_W-1:0] last_sent_count;
    int                         src_idle_pct;
    int                         snk_idle_pct;
    int                         mismatches = 0;
    int                         cycles = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic signed [mfda_pkg::ANGLE_W-1:0] cordic_angle(input int x,
                                                                         input int y);
        int vx, vy, acc, dx, dy, res, one_deg, lim, sh;
        one_deg = 1 << mfda_pkg::ANGLE_FRAC_BITS;
        if (x == 0) begin
            return mfda_pkg::ANGLE_W'((y < 0) ? -90 * one_deg : 90 * one_deg);
        end
        vx  = x << mfda_pkg::VEC_SHIFT;
        vy  = y << mfda_pkg::VEC_SHIFT;
        acc = 0;
        // left half plane: turn by a quarter first
        if (x < 0) begin
            if (y >= 0) begin
                vx  = y << mfda_pkg::VEC_SHIFT;
                vy  = -(x << mfda_pkg::VEC_SHIFT);
                acc = 90 << mfda_pkg::ACC_FRAC;
            end else begin
                vx  = -(y << mfda_pkg::VEC_SHIFT);
                vy  = x << mfda_pkg::VEC_SHIFT;
                acc = -(90 << mfda_pkg::ACC_FRAC);
            end
        end
        for (int i = 0; i < mfda_pkg::CORDIC_STEPS && i < ATAN_LEN; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx  += dx;
                vy  -= dy;
                acc += ATAN_DEG_Q16[i];
            end else begin
                vx  -= dx;
                vy  += dy;
                acc -= ATAN_DEG_Q16[i];
            end
        end
        sh  = mfda_pkg::ACC_FRAC - mfda_pkg::ANGLE_FRAC_BITS;
        res = (acc + (1 << (sh - 1))) >>> sh;
        lim = 180 * one_deg;
        if (res > lim) res = lim;
        if (res < -lim) res = -lim;
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return mfda_pkg::ANGLE_W'(res);
    endfunction

    function automatic t_reading decode_frame(input t_frame f);
        t_reading                   r;
        logic [mfda_pkg::CNT_W-1:0] cnt;
        r.field_x   = {f.frame_byte0, f.frame_byte4[7:4]};
        r.field_y   = {f.frame_byte1, f.frame_byte4[3:0]};
        r.field_z   = {f.frame_byte2, f.frame_byte5[3:0]};
        cnt         = f.frame_byte3[3:2];
        r.stuck     = (cnt == prev_count);
        prev_count  = r.stuck ? '0 : cnt;
        r.angle_deg = cordic_angle(int'(r.field_x), int'(r.field_y));
        return r;
    endfunction

    function automatic mfda_pkg::t_field rand_field(input bit zero_ok);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0 && zero_ok) return '0;
        if (roll == 1) return mfda_pkg::t_field'(int'($urandom_range(0, 8)) - 4);
        if (roll == 2) begin
            case ($urandom_range(0, 4))
                0:       return 12'h800;
                1:       return 12'h7FF;
                2:       return 12'hFFF;
                3:       return 12'h001;
                default: return 12'h000;
            endcase
        end
        return mfda_pkg::t_field'($urandom);
    endfunction

    // mostly a counter that steps by one, now and then a repeat or a jump
    function automatic t_frame rand_frame();
        t_frame                     f;
        mfda_pkg::t_field           x, y, z;
        logic [mfda_pkg::CNT_W-1:0] cnt;
        x = rand_field(1'b1);
        y = rand_field(1'b1);
        z = rand_field(1'b0);
        if ($urandom_range(0, 99) < 80) cnt = last_sent_count + 1'b1;
        else cnt = mfda_pkg::CNT_W'($urandom);
        last_sent_count = cnt;
        f.frame_byte0 = x[11:4];
        f.frame_byte1 = y[11:4];
        f.frame_byte2 = z[11:4];
        f.frame_byte3 = {4'($urandom), cnt, 2'($urandom)};
        f.frame_byte4 = {x[3:0], y[3:0]};
        f.frame_byte5 = {4'($urandom), z[3:0]};
        return f;
    endfunction

    // entered and left at a falling edge
    task automatic drive_frame(input t_frame f, input logic fixed_want, input t_reading want);
        t_reading r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            frame_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        frame_bus.valid       = 1'b1;
        frame_bus.frame_byte0 = f.frame_byte0;
        frame_bus.frame_byte1 = f.frame_byte1;
        frame_bus.frame_byte2 = f.frame_byte2;
        frame_bus.frame_byte3 = f.frame_byte3;
        frame_bus.frame_byte4 = f.frame_byte4;
        frame_bus.frame_byte5 = f.frame_byte5;
        @(posedge i_clk);
        while (!frame_bus.ready) @(posedge i_clk);
        r = decode_frame(f);
        if (fixed_want) r = want;
        readings_due.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        frame_bus.valid = 1'b0;
        while (readings_due.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        result_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_reading got, want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            got = '{result_bus.field_x, result_bus.field_y, result_bus.field_z,
                    result_bus.angle_deg, result_bus.stuck};
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected reading x %0d y %0d z %0d angle %0d stuck %0b",
                             $realtime, got.field_x, got.field_y, got.field_z,
                             got.angle_deg, got.stuck);
                end
            end else begin
                want = readings_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: reading mismatch, expected x %0d y %0d z %0d angle %0d stuck %0b",
                                 $realtime, want.field_x, want.field_y, want.field_z,
                                 want.angle_deg, want.stuck);
                        $display("%0t:                   actual x %0d y %0d z %0d angle %0d stuck %0b",
                                 $realtime, got.field_x, got.field_y, got.field_z,
                                 got.angle_deg, got.stuck);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        frame_bus.valid       = 1'b0;
        frame_bus.frame_byte0 = '0;
        frame_bus.frame_byte1 = '0;
        frame_bus.frame_byte2 = '0;
        frame_bus.frame_byte3 = '0;
        frame_bus.frame_byte4 = '0;
        frame_bus.frame_byte5 = '0;
        prev_count            = '0;
        last_sent_count       = '0;
        src_idle_pct          = 17;
        snk_idle_pct          = 71;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int n = 0; n < N_DIRECTED; n++) begin
            drive_frame(directed[n].frame, directed[n].fixed_want, directed[n].want);
        end
        last_sent_count = prev_count;

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 17;
                    snk_idle_pct = 71;
                end
                1: begin
                    src_idle_pct = 71;
                    snk_idle_pct = 17;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (n == RAND_PER_PHASE / 2) wait_drained();
                drive_frame(rand_frame(), 1'b0, '0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && readings_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
